FILE: rtl/ttfc_pkg.sv
// ============================================================================
// ttfc_pkg
// Shared types and constants for the 4x4 tiled texture format converter.
// ============================================================================
package ttfc_pkg;

   // texture_format codes
   typedef enum logic [2:0] {
      FMT_ARGB32   = 3'd0,
      FMT_PAL555   = 3'd1,
      FMT_PAL4A3   = 3'd2,
      FMT_RGBA5551 = 3'd3,
      FMT_YCBCR    = 3'd4
   } fmt_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_FORMAT     = 2'd0,
      CSR_RAW_WIDTH  = 2'd1,
      CSR_RAW_HEIGHT = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   // input word operations
   localparam logic OP_PAL_WRITE = 1'b0;
   localparam logic OP_CONVERT   = 1'b1;

   // YCbCr to RGB coefficients, scaled by 256
   localparam int unsigned K_Y     = 298;
   localparam int unsigned K_R_CR  = 409;
   localparam int unsigned K_G_CB  = 100;
   localparam int unsigned K_G_CR  = 208;
   localparam int unsigned K_B_CB  = 516;
   localparam int unsigned OFS_Y   = 56992;
   localparam int unsigned OFS_G   = 91776;
   localparam int unsigned OFS_B   = 13696;
   localparam int unsigned CH_MAX  = 65535;

   // width of the signed YCbCr sums
   localparam int SUM_W = 19;

   // clamp a scaled channel to 0..255
   function automatic logic [7:0] clamp_channel(input logic signed [SUM_W-1:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > SUM_W'(CH_MAX)) begin
         res = 8'hFF;
      end else begin
         res = v[15:8];
      end
      return res;
   endfunction

   // RGBA5551 to RGB5A3
   function automatic logic [15:0] to_rgb5a3(input logic [15:0] c);
      logic [15:0] res;
      if (c[0]) begin
         res = {1'b1, c[15:11], c[10:6], c[5:1]};
      end else begin
         res = {4'd0, c[15:12], c[10:7], c[5:2]};
      end
      return res;
   endfunction

endpackage

FILE: rtl/texture_tile_format_converter.sv
// ============================================================================
// texture_tile_format_converter
// Texel to 4x4 tiled halfword converter with palette store.
// ============================================================================
// Each request word either loads one palette entry or converts one texel into
// tiled destination halfwords. 16-bit formats and palette loads go at one word
// per cycle while the response side does not stall. 32-bit formats give two
// response words per texel (AR half, then GB half 16 halfwords on) through the
// single response port, so the next texel waits until both are taken. A texel
// passes stage 1, stage 2 and the response register in turn. The palette is a
// single-port synchronous RAM. Loads and lookups share its one port, with one
// access per accepted word, so a lookup always sees every earlier load. Palette
// entries hold no value until loaded.
// ============================================================================
module texture_tile_format_converter
   import ttfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 65536,
   parameter int MAX_SIDE        = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [9:0]  req_column,
   input  logic [9:0]  req_row,
   input  logic [31:0] req_texel_word,
   input  logic [15:0] req_palette_index,
   input  logic [31:0] req_palette_color,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_dest_index,
   output logic [15:0] rsp_halfword,
   output logic        rsp_last
);

   localparam int              PAL_AW   = $clog2(PALETTE_ENTRIES);
   localparam logic [16:0]     PAL_LIM  = 17'(PALETTE_ENTRIES);
   localparam logic [12:0]     SIDE_LIM = 13'(MAX_SIDE);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [2:0]  fmt_ff;
   logic [10:0] raw_w_ff;
   logic [10:0] raw_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_ARGB32;
         raw_w_ff <= 11'd1;
         raw_h_ff <= 11'd1;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FORMAT:     fmt_ff   <= csr_wdata[2:0];
            CSR_RAW_WIDTH:  raw_w_ff <= csr_wdata;
            CSR_RAW_HEIGHT: raw_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped raw size and padded size
   logic [11:0] rw, rh, pw, ph;
   logic        fmt_ok, fmt_wide;

   always_comb begin
      rw = ({2'b0, raw_w_ff} > SIDE_LIM) ? SIDE_LIM[11:0] : {1'b0, raw_w_ff};
      rh = ({2'b0, raw_h_ff} > SIDE_LIM) ? SIDE_LIM[11:0] : {1'b0, raw_h_ff};
      pw = 12'(rw + 12'd3) & ~12'd3;
      ph = 12'(rh + 12'd3) & ~12'd3;
      fmt_ok   = (fmt_ff == FMT_ARGB32) || (fmt_ff == FMT_PAL555) ||
                 (fmt_ff == FMT_PAL4A3) || (fmt_ff == FMT_RGBA5551) ||
                 (fmt_ff == FMT_YCBCR);
      fmt_wide = (fmt_ff == FMT_ARGB32) || (fmt_ff == FMT_YCBCR);
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, o_valid_ff;
   logic o_wide_ff, o_phase_ff;
   logic o_free, s2_free, s1_free, s2_adv, s1_adv, req_acc, rsp_acc;

   always_comb begin
      rsp_acc = o_valid_ff & ~rsp_stall;
      o_free  = ~o_valid_ff | (rsp_acc & (~o_wide_ff | o_phase_ff));
      s2_adv  = s2_valid_ff & o_free;
      s2_free = ~s2_valid_ff | s2_adv;
      s1_adv  = s1_valid_ff & s2_free;
      s1_free = ~s1_valid_ff | s1_adv;
      req_acc = req_valid & s1_free;
   end

   assign req_stall = ~s1_free;

   // ---------------------------------------------------------------------
   // Palette RAM: one access per accepted word
   // ---------------------------------------------------------------------
   logic [31:0]       pal_mem [PALETTE_ENTRIES];
   logic [31:0]       pal_rd_ff;
   logic [PAL_AW-1:0] pal_addr;
   logic              pal_we, pal_re;

   always_comb begin
      pal_we   = req_acc & (req_operation == OP_PAL_WRITE) &
                 ({1'b0, req_palette_index} < PAL_LIM);
      pal_re   = req_acc & (req_operation == OP_CONVERT);
      pal_addr = (req_operation == OP_CONVERT) ? req_texel_word[PAL_AW-1:0]
                                               : req_palette_index[PAL_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_addr] <= req_palette_color;
      end
      if (pal_re) begin
         pal_rd_ff <= pal_mem[pal_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: capture texel, bounds checks
   // ---------------------------------------------------------------------
   logic        s1_valid_in, s1_inside_in, s1_pal_oor_in;
   logic [9:0]  s1_col_ff, s1_row_ff;
   logic [31:0] s1_word_ff;
   logic        s1_inside_ff, s1_pal_oor_ff;

   always_comb begin
      s1_valid_in   = (req_operation == OP_CONVERT) & fmt_ok &
                      ({2'b0, req_column} < pw) & ({2'b0, req_row} < ph);
      s1_inside_in  = ({2'b0, req_column} < rw) & ({2'b0, req_row} < rh);
      s1_pal_oor_in = ({1'b0, req_texel_word[15:0]} >= PAL_LIM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_acc & s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_col_ff     <= req_column;
         s1_row_ff     <= req_row;
         s1_word_ff    <= req_texel_word;
         s1_inside_ff  <= s1_inside_in;
         s1_pal_oor_ff <= s1_pal_oor_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: tile address, YCbCr products, palette data
   // ---------------------------------------------------------------------
   logic [17:0] tile;
   logic [20:0] base_in, base2_in;
   logic [16:0] y_in, rcr_in;
   logic [14:0] gcb_in;
   logic [15:0] gcr_in;
   logic [17:0] bcb_in;

   always_comb begin
      tile = 18'(s1_row_ff[9:2] * pw[11:2]) + 18'(s1_col_ff[9:2]);
      if (fmt_wide) begin
         base_in  = 21'({tile, 1'b0, s1_row_ff[1:0], s1_col_ff[1:0]});
         base2_in = 21'({tile, 1'b1, s1_row_ff[1:0], s1_col_ff[1:0]});
      end else begin
         base_in  = 21'({tile, s1_row_ff[1:0], s1_col_ff[1:0]});
         base2_in = base_in;
      end
      y_in   = 17'(s1_word_ff[7:0]   * 9'(K_Y));
      rcr_in = 17'(s1_word_ff[23:16] * 9'(K_R_CR));
      gcb_in = 15'(s1_word_ff[15:8]  * 7'(K_G_CB));
      gcr_in = 16'(s1_word_ff[23:16] * 8'(K_G_CR));
      bcb_in = 18'(s1_word_ff[15:8]  * 10'(K_B_CB));
   end

   logic [20:0] s2_base_ff, s2_base2_ff;
   logic [16:0] s2_y_ff, s2_rcr_ff;
   logic [14:0] s2_gcb_ff;
   logic [15:0] s2_gcr_ff;
   logic [17:0] s2_bcb_ff;
   logic [31:0] s2_word_ff, s2_pal_ff;
   logic        s2_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_base_ff   <= base_in;
         s2_base2_ff  <= base2_in;
         s2_y_ff      <= y_in;
         s2_rcr_ff    <= rcr_in;
         s2_gcb_ff    <= gcb_in;
         s2_gcr_ff    <= gcr_in;
         s2_bcb_ff    <= bcb_in;
         s2_word_ff   <= s1_word_ff;
         s2_pal_ff    <= s1_pal_oor_ff ? 32'd0 : pal_rd_ff;
         s2_inside_ff <= s1_inside_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: format conversion into the response register
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] common, r_sum, g_sum, b_sum;
   logic [7:0]  r_ch, g_ch, b_ch;
   logic [15:0] hi_in, lo_in;

   always_comb begin
      common = signed'(SUM_W'(s2_y_ff)) - signed'(SUM_W'(OFS_Y));
      r_sum  = common + signed'(SUM_W'(s2_rcr_ff));
      g_sum  = common - signed'(SUM_W'(s2_gcb_ff)) - signed'(SUM_W'(s2_gcr_ff))
               + signed'(SUM_W'(OFS_G));
      b_sum  = common + signed'(SUM_W'(s2_bcb_ff)) - signed'(SUM_W'(OFS_B));
      r_ch   = clamp_channel(r_sum);
      g_ch   = clamp_channel(g_sum);
      b_ch   = clamp_channel(b_sum);

      hi_in = 16'd0;
      lo_in = 16'd0;
      if (s2_inside_ff) begin
         unique case (fmt_ff)
            FMT_ARGB32: begin
               hi_in = s2_word_ff[31:16];
               lo_in = s2_word_ff[15:0];
            end
            FMT_YCBCR: begin
               hi_in = {8'hFF, r_ch};
               lo_in = {g_ch, b_ch};
            end
            FMT_RGBA5551: hi_in = to_rgb5a3(s2_word_ff[15:0]);
            FMT_PAL555: hi_in = {1'b1, s2_pal_ff[23:19], s2_pal_ff[15:11],
                                 s2_pal_ff[7:3]};
            FMT_PAL4A3: hi_in = {1'b0, s2_pal_ff[31:29], s2_pal_ff[23:20],
                                 s2_pal_ff[15:12], s2_pal_ff[7:4]};
            default: ;
         endcase
      end
   end

   // response register: holds one texel, one or two words
   logic [20:0] o_base_ff, o_base2_ff;
   logic [15:0] o_hi_ff, o_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_phase_ff <= 1'b0;
         o_wide_ff  <= 1'b0;
      end else if (o_free) begin
         o_valid_ff <= s2_adv;
         o_phase_ff <= 1'b0;
         o_wide_ff  <= fmt_wide;
      end else if (rsp_acc) begin
         // first half of a wide texel taken
         o_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         o_base_ff  <= s2_base_ff;
         o_base2_ff <= s2_base2_ff;
         o_hi_ff    <= hi_in;
         o_lo_ff    <= lo_in;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_dest_index = o_phase_ff ? o_base2_ff : o_base_ff;
   assign rsp_halfword   = o_phase_ff ? o_lo_ff : o_hi_ff;
   assign rsp_last       = ~o_wide_ff | o_phase_ff;

endmodule

FILE: tb/sv/ttfc_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ttfc_checker
// Watches the register port and both channels of the tiled texture converter,
// works out the halfword words each accepted texel should give and compares
// every accepted response word with the oldest one still due.
// ============================================================================
module ttfc_checker
   import ttfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [9:0]  req_column,
   input  logic [9:0]  req_row,
   input  logic [31:0] req_texel_word,
   input  logic [15:0] req_palette_index,
   input  logic [31:0] req_palette_color,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [20:0] rsp_dest_index,
   input  logic [15:0] rsp_halfword,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_words
);

   localparam int SIDE_LIMIT   = 1024;
   localparam int REPORT_LIMIT = 10;
   localparam int CHANNEL_FULL = 65535;

   // YCbCr to RGB, all gains scaled by 256
   localparam int Y_GAIN    = 298;
   localparam int Y_OFFSET  = 56992;
   localparam int R_CR_GAIN = 409;
   localparam int G_CB_GAIN = 100;
   localparam int G_CR_GAIN = 208;
   localparam int G_OFFSET  = 91776;
   localparam int B_CB_GAIN = 516;
   localparam int B_OFFSET  = 13696;

   typedef struct packed {
      logic [20:0] dest_index;
      logic [15:0] halfword;
      logic        last;
   } tiled_word_type;

   tiled_word_type due_words[$];
   logic [31:0] palette_mem [0:65535];
   logic [2:0]  cur_format;
   logic [10:0] cur_width;
   logic [10:0] cur_height;

   // scaled channel sum to 0..255
   function automatic logic [7:0] sat_channel(input int v);
      if (v < 0) return 8'd0;
      if (v > CHANNEL_FULL) return 8'hFF;
      return v[15:8];
   endfunction

   function automatic logic [15:0] rgba5551_to_5a3(input logic [15:0] c);
      if (c[0]) return {1'b1, c[15:11], c[10:6], c[5:1]};
      return {4'd0, c[15:12], c[10:7], c[5:2]};
   endfunction

   function automatic void log_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%0t ttfc_checker: %s", $time, what);
   endfunction

   // queue the halfword words one texel should give under the current setting
   function automatic void project_texel(input logic [9:0] col, input logic [9:0] row,
                                         input logic [31:0] texel);
      int unsigned rw, rh, pw, ph, tile, base;
      logic [3:0]  off;
      logic [15:0] hi, lo;
      logic [31:0] pal;
      int          y, cb, cr, luma;
      logic        in_raw;
      tiled_word_type w;
      if (cur_format > FMT_YCBCR) return;
      rw = (cur_width > SIDE_LIMIT) ? SIDE_LIMIT : cur_width;
      rh = (cur_height > SIDE_LIMIT) ? SIDE_LIMIT : cur_height;
      pw = (rw + 3) & 32'hFFFF_FFFC;
      ph = (rh + 3) & 32'hFFFF_FFFC;
      if (col >= pw || row >= ph) return;
      in_raw = (col < rw) && (row < rh);
      tile = (row >> 2) * (pw >> 2) + (col >> 2);
      off = {row[1:0], col[1:0]};
      hi = '0;
      lo = '0;
      if (cur_format == FMT_ARGB32 || cur_format == FMT_YCBCR) begin
         // 32-bit tile: AR half, then GB half 16 halfwords on
         base = tile * 32 + off;
         if (in_raw && cur_format == FMT_ARGB32) begin
            hi = texel[31:16];
            lo = texel[15:0];
         end else if (in_raw) begin
            y = texel[7:0];
            cb = texel[15:8];
            cr = texel[23:16];
            luma = Y_GAIN * y - Y_OFFSET;
            hi = {8'hFF, sat_channel(luma + R_CR_GAIN * cr)};
            lo = {sat_channel(luma - G_CB_GAIN * cb - G_CR_GAIN * cr + G_OFFSET),
                  sat_channel(luma + B_CB_GAIN * cb - B_OFFSET)};
         end
         w.dest_index = base[20:0];
         w.halfword = hi;
         w.last = 1'b0;
         due_words.push_back(w);
         w.dest_index = 21'(base + 16);
         w.halfword = lo;
         w.last = 1'b1;
         due_words.push_back(w);
      end else begin
         // 16-bit tile: one halfword
         base = tile * 16 + off;
         if (in_raw && cur_format == FMT_RGBA5551) begin
            hi = rgba5551_to_5a3(texel[15:0]);
         end else if (in_raw) begin
            pal = palette_mem[texel[15:0]];
            if (cur_format == FMT_PAL555) begin
               hi = {1'b1, pal[23:19], pal[15:11], pal[7:3]};
            end else begin
               hi = {1'b0, pal[31:29], pal[23:20], pal[15:12], pal[7:4]};
            end
         end
         w.dest_index = base[20:0];
         w.halfword = hi;
         w.last = 1'b1;
         due_words.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      tiled_word_type got, want;
      if (reset) begin
         cur_format = FMT_ARGB32;
         cur_width = 11'd1;
         cur_height = 11'd1;
         due_words.delete();
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_idx_type'(csr_index))
               CSR_FORMAT:     cur_format = csr_wdata[2:0];
               CSR_RAW_WIDTH:  cur_width = csr_wdata;
               CSR_RAW_HEIGHT: cur_height = csr_wdata;
               default: ;
            endcase
         end
         // response words against the oldest one due
         if (rsp_valid && !rsp_stall) begin
            got.dest_index = rsp_dest_index;
            got.halfword = rsp_halfword;
            got.last = rsp_last;
            if (due_words.size() == 0) begin
               log_failure($sformatf("unexpected word: index %0d half %h last %b",
                                     got.dest_index, got.halfword, got.last));
            end else begin
               want = due_words.pop_front();
               if (got !== want) begin
                  log_failure($sformatf({"word mismatch: expected index %0d half %h last %b,",
                                         " got index %0d half %h last %b"},
                                        want.dest_index, want.halfword, want.last,
                                        got.dest_index, got.halfword, got.last));
               end
            end
         end
         // request words
         if (req_valid && !req_stall) begin
            if (req_operation == OP_PAL_WRITE) begin
               palette_mem[req_palette_index] = req_palette_color;
            end else begin
               project_texel(req_column, req_row, req_texel_word);
            end
         end
      end
      pending_words <= due_words.size();
   end

endmodule

FILE: tb/sv/tb_texture_tile_format_converter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_texture_tile_format_converter
// Drives palette loads and texels through the tiled texture converter under
// a series of format and size settings, first a directed set of corner
// cases, then random phases with random gaps and stalls on both channels.
// ============================================================================
module tb_texture_tile_format_converter;
   import ttfc_pkg::*;

   localparam int MAX_GAP         = 13;
   localparam int SETTLE_CYCLES   = 12;
   localparam int DRAIN_LIMIT     = 50000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 16;
   localparam int WORDS_PER_PHASE = 50;
   localparam int HOLD_PHASE      = 3;
   localparam int SIDE_LIMIT      = 1024;

   // format codes the block does not know
   localparam logic [2:0] FMT_FIRST_UNDEFINED = 3'd5;
   localparam logic [2:0] FMT_LAST_UNDEFINED  = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [10:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic        req_operation;
   logic [9:0]  req_column;
   logic [9:0]  req_row;
   logic [31:0] req_texel_word;
   logic [15:0] req_palette_index;
   logic [31:0] req_palette_color;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [20:0] rsp_dest_index;
   logic [15:0] rsp_halfword;
   logic        rsp_last;
   int          fail_count;
   int          pending_words;

   bit          quiet_sender;
   bit          quiet_receiver;
   bit          hold_off_req;
   logic [2:0]  fmt_now = FMT_ARGB32;
   int unsigned side_w = 1;
   int unsigned side_h = 1;
   logic [15:0] loaded_entries[$];

   always #5 clock = ~clock;

   texture_tile_format_converter dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_texel_word    (req_texel_word),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_halfword      (rsp_halfword),
      .rsp_last          (rsp_last)
   );

   ttfc_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_column        (req_column),
      .req_row           (req_row),
      .req_texel_word    (req_texel_word),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_index    (rsp_dest_index),
      .rsp_halfword      (rsp_halfword),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_words     (pending_words)
   );

   // watchdog
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: random stalls, a long hold-off when asked
   initial begin : drain_side
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            gap = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else if (quiet_receiver) begin
            gap = 0;
         end else begin
            gap = $urandom_range(MAX_GAP, 0);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // offer one request word after a random gap, return once it is taken
   task automatic send_word(input logic op, input logic [9:0] col, input logic [9:0] row,
                            input logic [31:0] texel, input logic [15:0] pidx,
                            input logic [31:0] pcol);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_column <= col;
      req_row <= row;
      req_texel_word <= texel;
      req_palette_index <= pidx;
      req_palette_color <= pcol;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op == OP_PAL_WRITE) loaded_entries.push_back(pidx);
   endtask

   task automatic load_palette(input logic [15:0] pidx, input logic [31:0] pcol);
      send_word(OP_PAL_WRITE, 10'($urandom_range(1023, 0)), 10'($urandom_range(1023, 0)),
                $urandom(), pidx, pcol);
   endtask

   task automatic convert(input logic [9:0] col, input logic [9:0] row,
                          input logic [31:0] texel);
      send_word(OP_CONVERT, col, row, texel, 16'($urandom_range(65535, 0)), $urandom());
   endtask

   // stop offering and let every due word out, then give silent words time
   task automatic wait_idle();
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (pending_words != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // new setting, written only once the block is idle
   task automatic configure(input logic [2:0] fmt, input logic [10:0] w, input logic [10:0] h);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= CSR_FORMAT;
      csr_wdata <= {8'd0, fmt};
      @(negedge clock);
      csr_index <= CSR_RAW_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_RAW_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      // the spare index should be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= 11'($urandom_range(2047, 0));
      @(negedge clock);
      csr_write <= 1'b0;
      fmt_now = fmt;
      side_w = w;
      side_h = h;
   endtask

   // palette formats only look up entries already loaded
   function automatic logic [31:0] pick_texel();
      logic [31:0] w;
      w = $urandom();
      if (fmt_now == FMT_PAL555 || fmt_now == FMT_PAL4A3)
         w[15:0] = loaded_entries[$urandom_range(loaded_entries.size() - 1, 0)];
      return w;
   endfunction

   // mostly inside the padded texture, now and then anywhere
   function automatic logic [9:0] pick_coord(input int unsigned side);
      int unsigned padded;
      padded = ((side > SIDE_LIMIT ? SIDE_LIMIT : side) + 3) & 32'hFFFF_FFFC;
      if (padded == 0 || $urandom_range(9, 0) == 0) return 10'($urandom_range(1023, 0));
      return 10'($urandom_range(padded - 1, 0));
   endfunction

   // raw side: mostly small, sometimes full, zero or oversized
   function automatic logic [10:0] pick_side();
      case ($urandom_range(15, 0))
         0:       return 11'd0;
         1:       return 11'd1024;
         2:       return 11'($urandom_range(2047, 1025));
         3:       return 11'($urandom_range(1023, 1));
         default: return 11'($urandom_range(40, 1));
      endcase
   endfunction

   initial begin : stimulus
      int phase, k;
      logic [2:0]  fmt;
      logic [10:0] w, h;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FORMAT;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_operation = OP_CONVERT;
      req_column = '0;
      req_row = '0;
      req_texel_word = '0;
      req_palette_index = '0;
      req_palette_color = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset setting: argb32, 1x1
      convert(10'd0, 10'd0, 32'hFFFF_FFFF);
      convert(10'd3, 10'd3, 32'h1234_5678);     // padding, zero halves
      convert(10'd4, 10'd0, 32'hFFFF_FFFF);     // beyond padding, silent

      load_palette(16'h0000, 32'hFFFF_FFFF);
      load_palette(16'hFFFF, 32'h0000_0000);
      load_palette(16'hA5C3, 32'h7F80_01FE);

      configure(FMT_PAL555, 11'd1024, 11'd1024);
      convert(10'd1023, 10'd1023, 32'h0000_FFFF);
      convert(10'd0, 10'd0, 32'hFFFF_0000);
      convert(10'd512, 10'd7, 32'h5A5A_A5C3);

      configure(FMT_PAL4A3, 11'd3, 11'd5);
      convert(10'd2, 10'd4, 32'hFFFF_A5C3);
      convert(10'd3, 10'd4, 32'h0000_0000);     // padding column
      convert(10'd0, 10'd7, 32'h0000_FFFF);     // padding row

      configure(FMT_RGBA5551, 11'd5, 11'd3);
      convert(10'd4, 10'd2, 32'hFFFF_FFFF);     // alpha bit set
      convert(10'd0, 10'd0, 32'h0000_FFFE);     // alpha bit clear
      convert(10'd7, 10'd3, 32'hFFFF_FFFF);
      convert(10'd8, 10'd0, 32'hFFFF_FFFF);

      // YCbCr: clamps at both ends, blue kept
      configure(FMT_YCBCR, 11'd4, 11'd4);
      convert(10'd0, 10'd0, 32'h0000_0000);
      convert(10'd1, 10'd0, 32'h00FF_FFFF);
      convert(10'd2, 10'd0, 32'hFF80_8080);
      convert(10'd3, 10'd3, 32'h0000_FF00);
      convert(10'd0, 10'd1, 32'h00FF_00FF);

      // oversized raw size is taken as full size
      configure(FMT_ARGB32, 11'd2047, 11'd1025);
      convert(10'd1023, 10'd1023, 32'hDEAD_BEEF);

      configure(FMT_LAST_UNDEFINED, 11'd8, 11'd8);
      convert(10'd0, 10'd0, 32'hFFFF_FFFF);

      configure(FMT_ARGB32, 11'd0, 11'd16);
      convert(10'd0, 10'd0, 32'hFFFF_FFFF);

      // random phases
      for (phase = 0; phase < PHASES; phase++) begin
         k = $urandom_range(19, 0);
         fmt = (k < 18) ? 3'(k % 5) : 3'($urandom_range(FMT_LAST_UNDEFINED, FMT_FIRST_UNDEFINED));
         w = pick_side();
         h = pick_side();
         quiet_sender = ($urandom_range(3, 0) == 0);
         quiet_receiver = ($urandom_range(3, 0) == 0);
         if (phase == HOLD_PHASE) begin
            // sender keeps offering while the response side holds off
            fmt = FMT_ARGB32;
            w = 11'd64;
            h = 11'd64;
            quiet_sender = 1'b1;
         end
         configure(fmt, w, h);
         if (phase == HOLD_PHASE) hold_off_req = 1'b1;
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            if ($urandom_range(7, 0) == 0)
               load_palette(16'($urandom_range(65535, 0)), $urandom());
            else
               convert(pick_coord(side_w), pick_coord(side_h), pick_texel());
         end
      end

      wait_idle();
      if (fail_count == 0 && pending_words == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
